// File: sv/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and codes for the decreasing-run tracker with undo.
// ----------------------------------------------------------------------------
package lpt_pkg;

    localparam int unsigned OutLenW = 11;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2,
        OP_PROBE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANK  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_PUSH_RD,
        S_PUSH_WR,
        S_POP_RD,
        S_POP_WR,
        S_QRY_RD,
        S_QRY_DATA,
        S_DONE
    } t_state;

endpackage

// File: sv/lds_patience_tracker_with_undo_core.sv
// ----------------------------------------------------------------------------
// lds_patience_tracker_with_undo_core
// Patience sorting tracker of the longest decreasing run, with LIFO undo.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  in       | i_in_valid / o_in_stall | i_op i_value i_rank
//  out      | o_out_valid/ i_out_stall| o_status o_lds_length o_ending_length
//           |                         | o_top_value o_sequence_length
//  cfg      | i_cfg_we                | i_cfg_wdata (strict mode)
//
//  one request at a time; push and probe walk a chain of clog2(MAX_ITEMS+1)
//  search cells, each a midpoint read of the pile top memory; pop reads the
//  undo record, then restores the pile top, and query reads one pile top.
//  reset clears counts and sets strict mode; memories hold no reset value.
//  a stalled result is held in the output register while the next request
//  waits in the sequencer.
// ----------------------------------------------------------------------------
module lds_patience_tracker_with_undo_core
    import lpt_pkg::*;
#(
    parameter int unsigned MAX_ITEMS   = 1024,
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_value,
    input  logic [10:0] i_rank,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [10:0] o_lds_length,
    output logic [10:0] o_ending_length,
    output logic [63:0] o_top_value,
    output logic [10:0] o_sequence_length
);

    localparam int unsigned VW    = VALUE_WIDTH;
    localparam int unsigned IDXW  = $clog2(MAX_ITEMS);
    localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
    localparam int unsigned NCELL = $clog2(MAX_ITEMS + 1);
    localparam int unsigned CMPW  = (CW > OutLenW) ? CW : OutLenW;

    t_state        r_state, n_state;
    logic          r_strict;
    logic [CW-1:0] r_pile_cnt, n_pile_cnt;
    logic [CW-1:0] r_elem_cnt, n_elem_cnt;
    t_op           r_op;
    logic [VW-1:0] r_val;
    logic [OutLenW-1:0] r_rank;
    logic [CW-1:0] r_idx;
    t_status       r_res_st, n_res_st;
    logic [CW-1:0] r_res_end, n_res_end;
    logic [VW-1:0] r_res_top, n_res_top;

    logic          r_out_vld;
    logic [1:0]    r_out_st;
    logic [OutLenW-1:0] r_out_lds, r_out_end, r_out_seq;
    logic [VW-1:0] r_out_top;

    logic [VW-1:0]   r_pt_mem [MAX_ITEMS];
    logic [VW-1:0]   r_pt_rd;
    logic            w_pt_we;
    logic [IDXW-1:0] w_pt_waddr, w_pt_raddr;
    logic [VW-1:0]   w_pt_wdata;

    logic [IDXW-1:0] r_ep_mem [MAX_ITEMS];
    logic [VW-1:0]   r_eprior_mem [MAX_ITEMS];
    logic            r_eopen_mem [MAX_ITEMS];
    logic [IDXW-1:0] r_ep_rd;
    logic [VW-1:0]   r_eprior_rd;
    logic            r_eopen_rd;
    logic            w_em_we;
    logic [IDXW-1:0] w_em_addr;
    logic [VW-1:0]   w_em_prior;
    logic            w_em_open;

    logic            w_in_acc, w_out_free, w_load_out;
    logic            w_start;
    logic [NCELL:0]  w_tok_vld;
    logic [CW-1:0]   w_tok_lo [NCELL+1];
    logic [CW-1:0]   w_tok_hi [NCELL+1];
    logic [NCELL-1:0] w_req;
    logic [IDXW-1:0] w_addr [NCELL];
    logic [IDXW-1:0] w_chain_addr;
    logic [VW-1:0]   w_in_val;
    logic            w_full;

    assign w_in_val   = i_value[VW-1:0];
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = ~r_out_vld | ~i_out_stall;
    assign w_full     = (r_elem_cnt == CW'(MAX_ITEMS));
    assign w_start    = w_in_acc & ((t_op'(i_op) == OP_PROBE) ||
                        ((t_op'(i_op) == OP_PUSH) && !w_full));

    // search chain
    assign w_tok_vld[0] = w_start;
    assign w_tok_lo[0]  = '0;
    assign w_tok_hi[0]  = r_pile_cnt;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        lpt_cell #(
            .CW   (CW),
            .IDXW (IDXW),
            .VW   (VW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_vld     (w_tok_vld[g]),
            .i_lo      (w_tok_lo[g]),
            .i_hi      (w_tok_hi[g]),
            .i_value   (r_val),
            .i_strict  (r_strict),
            .i_rd_data (r_pt_rd),
            .o_req     (w_req[g]),
            .o_addr    (w_addr[g]),
            .o_vld     (w_tok_vld[g+1]),
            .o_lo      (w_tok_lo[g+1]),
            .o_hi      (w_tok_hi[g+1])
        );
    end

    always_comb begin
        w_chain_addr = '0;
        for (int i = 0; i < NCELL; i++) begin
            if (w_req[i]) begin
                w_chain_addr = w_chain_addr | w_addr[i];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_pile_cnt = r_pile_cnt;
        n_elem_cnt = r_elem_cnt;
        n_res_st   = r_res_st;
        n_res_end  = r_res_end;
        n_res_top  = r_res_top;
        w_pt_we    = 1'b0;
        w_pt_waddr = r_idx[IDXW-1:0];
        w_pt_wdata = r_val;
        w_pt_raddr = w_chain_addr;
        w_em_we    = 1'b0;
        w_em_addr  = r_elem_cnt[IDXW-1:0];
        w_em_prior = '0;
        w_em_open  = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_st  = ST_OK;
                    n_res_end = '0;
                    n_res_top = '0;
                    unique case (t_op'(i_op))
                        OP_PUSH: begin
                            if (w_full) begin
                                n_res_st = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        OP_POP: begin
                            if (r_elem_cnt == '0) begin
                                n_res_st = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        OP_QUERY: begin
                            if ((i_rank == '0) ||
                                (CMPW'(i_rank) > CMPW'(r_pile_cnt))) begin
                                n_res_st = ST_RANK;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_QRY_RD;
                            end
                        end
                        OP_PROBE: n_state = S_SEARCH;
                        default:  n_state = S_SEARCH;
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_tok_vld[NCELL]) begin
                    if (r_op == OP_PROBE) begin
                        n_res_end = w_tok_lo[NCELL] + CW'(1);
                        n_state   = S_DONE;
                    end else if (w_tok_lo[NCELL] < r_pile_cnt) begin
                        n_state = S_PUSH_RD;
                    end else begin
                        n_state = S_PUSH_WR;
                    end
                end
            end
            S_PUSH_RD: begin
                w_pt_raddr = r_idx[IDXW-1:0];
                n_state    = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                w_pt_we = 1'b1;
                w_em_we = 1'b1;
                if (r_idx < r_pile_cnt) begin
                    w_em_prior = r_pt_rd;
                end else begin
                    w_em_open  = 1'b1;
                    n_pile_cnt = r_pile_cnt + CW'(1);
                end
                n_elem_cnt = r_elem_cnt + CW'(1);
                n_res_end  = r_idx + CW'(1);
                n_state    = S_DONE;
            end
            S_POP_RD: begin
                w_em_addr = IDXW'(r_elem_cnt - CW'(1));
                n_state   = S_POP_WR;
            end
            S_POP_WR: begin
                w_pt_waddr = r_ep_rd;
                w_pt_wdata = r_eprior_rd;
                if (r_eopen_rd) begin
                    if (r_pile_cnt != '0) begin
                        n_pile_cnt = r_pile_cnt - CW'(1);
                    end
                end else begin
                    w_pt_we = 1'b1;
                end
                n_elem_cnt = r_elem_cnt - CW'(1);
                n_res_end  = CW'(r_ep_rd) + CW'(1);
                n_state    = S_DONE;
            end
            S_QRY_RD: begin
                w_pt_raddr = IDXW'(r_rank - OutLenW'(1));
                n_state    = S_QRY_DATA;
            end
            S_QRY_DATA: begin
                n_res_top = r_pt_rd;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_strict   <= 1'b1;
            r_pile_cnt <= '0;
            r_elem_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pile_cnt <= n_pile_cnt;
            r_elem_cnt <= n_elem_cnt;
            if (i_cfg_we) begin
                r_strict <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_st  <= n_res_st;
        r_res_end <= n_res_end;
        r_res_top <= n_res_top;
        if (w_in_acc) begin
            r_op   <= t_op'(i_op);
            r_val  <= w_in_val;
            r_rank <= i_rank;
        end
        if (r_state == S_SEARCH && w_tok_vld[NCELL]) begin
            r_idx <= w_tok_lo[NCELL];
        end
        if (w_load_out) begin
            r_out_st  <= r_res_st;
            r_out_end <= OutLenW'(r_res_end);
            r_out_top <= r_res_top;
            r_out_lds <= OutLenW'(r_pile_cnt);
            r_out_seq <= OutLenW'(r_elem_cnt);
        end
    end

    // pile top memory
    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[w_pt_waddr] <= w_pt_wdata;
        end
        r_pt_rd <= r_pt_mem[w_pt_raddr];
    end

    // per element undo record
    always_ff @(posedge i_clk) begin
        if (w_em_we) begin
            r_ep_mem[w_em_addr]     <= r_idx[IDXW-1:0];
            r_eprior_mem[w_em_addr] <= w_em_prior;
            r_eopen_mem[w_em_addr]  <= w_em_open;
        end
        r_ep_rd     <= r_ep_mem[w_em_addr];
        r_eprior_rd <= r_eprior_mem[w_em_addr];
        r_eopen_rd  <= r_eopen_mem[w_em_addr];
    end

    assign o_out_valid       = r_out_vld;
    assign o_status          = r_out_st;
    assign o_lds_length      = r_out_lds;
    assign o_ending_length   = r_out_end;
    assign o_top_value       = 64'($signed(r_out_top));
    assign o_sequence_length = r_out_seq;

`ifndef SYNTHESIS
    a_piles_le_elems: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pile_cnt <= r_elem_cnt)
        else $error("pile count above element count");

    a_one_reader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_req))
        else $error("more than one search cell reading");

    a_pop_undo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP_WR |=> r_elem_cnt == $past(r_elem_cnt) - CW'(1))
        else $error("pop did not drop one element");

    a_search_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req != '0 |-> r_state == S_SEARCH)
        else $error("search read outside search");
`endif

endmodule

// File: sv/lpt_cell.sv
// ----------------------------------------------------------------------------
// lpt_cell
// One binary search step: reads the pile top at the midpoint, narrows the
// range and hands it to the next cell.
// ----------------------------------------------------------------------------
module lpt_cell
    import lpt_pkg::*;
#(
    parameter int unsigned CW   = 11,
    parameter int unsigned IDXW = 10,
    parameter int unsigned VW   = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [CW-1:0] i_lo,
    input  logic [CW-1:0] i_hi,
    input  logic [VW-1:0] i_value,
    input  logic          i_strict,
    input  logic [VW-1:0] i_rd_data,
    output logic          o_req,
    output logic [IDXW-1:0] o_addr,
    output logic          o_vld,
    output logic [CW-1:0] o_lo,
    output logic [CW-1:0] o_hi
);

    logic          r_vld;
    logic          r_req;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] w_mid;
    logic          w_open;
    logic          w_before;

    assign w_open = r_lo < r_hi;
    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        if (i_strict) begin
            w_before = $signed(i_rd_data) > $signed(i_value);
        end else begin
            w_before = $signed(i_rd_data) >= $signed(i_value);
        end
    end

    assign o_req  = r_vld & r_req & w_open;
    assign o_addr = w_mid[IDXW-1:0];
    assign o_vld  = r_vld & ~r_req;

    always_comb begin
        o_lo = r_lo;
        o_hi = r_hi;
        if (w_open) begin
            if (w_before) begin
                o_lo = w_mid + CW'(1);
            end else begin
                o_hi = w_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_req <= 1'b0;
        end else if (i_vld) begin
            r_vld <= 1'b1;
            r_req <= 1'b1;
        end else if (r_req) begin
            r_req <= 1'b0;
        end else begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_lo <= i_lo;
            r_hi <= i_hi;
        end
    end

endmodule

// File: bench/tb_lds_patience_tracker_with_undo_core.sv
// ----------------------------------------------------------------------------
// tb_lds_patience_tracker_with_undo_core
// Checks the decreasing-run tracker against its own predictor: a directed
// table first (empty pop, bad ranks, extremes, ties), then random pushes,
// pops, queries and probes in both modes, a fill past full and undo across
// mode changes, with random gaps on the request side and result stalls.
// ----------------------------------------------------------------------------
module tb_lds_patience_tracker_with_undo_core;
    import lpt_pkg::*;

    localparam int Depth    = 1024;
    localparam int CycleCap = 2000000;
    localparam logic signed [63:0] VMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VMin = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        t_status      status;
        logic [10:0]  lds_len;
        logic [10:0]  end_len;
        logic [63:0]  top;
        logic [10:0]  seq_len;
    } run_res_t;

    typedef struct {
        t_op                 op;
        logic signed [63:0]  value;
        logic [10:0]         rank;
        bit                  typed;
        run_res_t            res;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = OP_PROBE;
    logic [63:0] i_value = '0;
    logic [10:0] i_rank = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [10:0] o_lds_length;
    logic [10:0] o_ending_length;
    logic [63:0] o_top_value;
    logic [10:0] o_sequence_length;

    lds_patience_tracker_with_undo_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit                 strict_q = 1'b1;
    logic signed [63:0] tops [Depth];
    logic [9:0]         elem_pile [Depth];
    logic signed [63:0] elem_prior [Depth];
    bit                 elem_opened [Depth];
    int                 pile_cnt = 0;
    int                 elem_cnt = 0;

    run_res_t pending_q [$];
    int errors = 0;
    int n_req = 0, n_res = 0, n_full = 0, n_empty = 0, n_rank = 0;
    int cycles = 0;
    bit quiet_in = 0, quiet_out = 0;

    function automatic int pile_for(logic signed [63:0] v);
        int lo = 0, hi = pile_cnt, mid;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (strict_q ? (tops[mid] > v) : (tops[mid] >= v)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic run_res_t tracker_step(t_op op, logic signed [63:0] v,
                                              logic [10:0] rank);
        run_res_t r;
        int idx;
        r = '{status: ST_OK, default: '0};
        case (op)
            OP_PUSH: begin
                if (elem_cnt >= Depth) begin
                    r.status = ST_FULL;
                end else begin
                    idx = pile_for(v);
                    elem_pile[elem_cnt] = idx[9:0];
                    elem_opened[elem_cnt] = (idx >= pile_cnt);
                    elem_prior[elem_cnt] = (idx < pile_cnt) ? tops[idx] : '0;
                    if (idx >= pile_cnt) pile_cnt++;
                    tops[idx] = v;
                    elem_cnt++;
                    r.end_len = 11'(idx + 1);
                end
            end
            OP_POP: begin
                if (elem_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    elem_cnt--;
                    idx = int'(elem_pile[elem_cnt]);
                    if (elem_opened[elem_cnt]) pile_cnt--;
                    else tops[idx] = elem_prior[elem_cnt];
                    r.end_len = 11'(idx + 1);
                end
            end
            OP_QUERY: begin
                if (rank == 0 || rank > pile_cnt) r.status = ST_RANK;
                else r.top = tops[rank - 1];
            end
            default: r.end_len = 11'(pile_for(v) + 1);
        endcase
        r.lds_len = 11'(pile_cnt);
        r.seq_len = 11'(elem_cnt);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h", n_res, what, got, want);
        errors++;
    endtask

    task automatic write_mode(bit strict);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= strict;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        strict_q = strict;
    endtask

    // one request; typed rows use their own expectation
    task automatic send(t_op op, logic signed [63:0] v, logic [10:0] rank,
                        bit typed = 0, run_res_t want = '0);
        int gap;
        run_res_t r;
        gap = quiet_in ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_value <= v;
        i_rank <= rank;
        do @(posedge i_clk); while (o_in_stall);
        r = tracker_step(op, v, rank);
        pending_q.insert(pending_q.size(), typed ? want : r);
        n_req++;
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_EMPTY) n_empty++;
        if (r.status == ST_RANK) n_rank++;
        if ($urandom_range(0, 99) == 0) quiet_in = ~quiet_in;
    endtask

    function automatic logic signed [63:0] any_value();
        case ($urandom_range(0, 5))
            0, 1:    return $signed(64'($urandom_range(0, 15))) - 8;
            2:       return {$urandom, $urandom};
            3:       return $urandom_range(0, 1) ? VMax : VMin;
            4:       return $signed({{32{1'b0}}, $urandom}) - 64'sd2147483648;
            default: return $signed(64'($urandom_range(0, 200))) - 100;
        endcase
    endfunction

    function automatic logic [10:0] any_rank();
        if ($urandom_range(0, 9) == 0) return 11'($urandom);
        return 11'($urandom_range(0, pile_cnt + 1));
    endfunction

    task automatic random_mix(int n, int push_pct, int pop_pct);
        int p;
        repeat (n) begin
            p = $urandom_range(0, 99);
            if (p < push_pct) send(OP_PUSH, any_value(), '0);
            else if (p < push_pct + pop_pct) send(OP_POP, any_value(), any_rank());
            else if (p < push_pct + pop_pct + 15) send(OP_QUERY, any_value(), any_rank());
            else send(OP_PROBE, any_value(), any_rank());
        end
    endtask

    // result side: random stalls, compare with oldest expectation
    always @(posedge i_clk) begin
        int hold;
        run_res_t want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_res++;
                if (pending_q.size() == 0) begin
                    $display("unexpected result %0d", n_res);
                    errors++;
                end else begin
                    want = pending_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_lds_length !== want.lds_len)
                        report_mismatch("lds_length", 64'(o_lds_length),
                                        64'(want.lds_len));
                    if (o_ending_length !== want.end_len)
                        report_mismatch("ending_length", 64'(o_ending_length),
                                        64'(want.end_len));
                    if (o_top_value !== want.top)
                        report_mismatch("top_value", o_top_value, want.top);
                    if (o_sequence_length !== want.seq_len)
                        report_mismatch("sequence_length", 64'(o_sequence_length),
                                        64'(want.seq_len));
                end
                if ($urandom_range(0, 60) == 0) quiet_out = ~quiet_out;
            end
            hold = quiet_out ? 0 : $urandom_range(0, 5);
            i_out_stall <= (hold > 3);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CycleCap) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    row_t table_rows [] = '{
        '{OP_POP,   64'sd0, 11'd0,    1, '{ST_EMPTY, 11'd0, 11'd0, 64'd0, 11'd0}},
        '{OP_QUERY, 64'sd0, 11'd0,    1, '{ST_RANK,  11'd0, 11'd0, 64'd0, 11'd0}},
        '{OP_QUERY, 64'sd0, 11'd1,    1, '{ST_RANK,  11'd0, 11'd0, 64'd0, 11'd0}},
        '{OP_PROBE, VMin,   11'h7FF,  1, '{ST_OK,    11'd0, 11'd1, 64'd0, 11'd0}},
        '{OP_PUSH,  VMax,   11'd0,    1, '{ST_OK,    11'd1, 11'd1, 64'd0, 11'd1}},
        '{OP_PUSH,  VMax,   11'd0,    1, '{ST_OK,    11'd1, 11'd1, 64'd0, 11'd2}},
        '{OP_PUSH,  VMin,   11'd0,    1, '{ST_OK,    11'd2, 11'd2, 64'd0, 11'd3}},
        '{OP_QUERY, 64'sd0, 11'd1,    1, '{ST_OK,    11'd2, 11'd0, VMax,  11'd3}},
        '{OP_QUERY, 64'sd0, 11'd2,    1, '{ST_OK,    11'd2, 11'd0, VMin,  11'd3}},
        '{OP_QUERY, 64'sd0, 11'd3,    1, '{ST_RANK,  11'd2, 11'd0, 64'd0, 11'd3}},
        '{OP_QUERY, 64'sd0, 11'h7FF,  1, '{ST_RANK,  11'd2, 11'd0, 64'd0, 11'd3}},
        '{OP_PROBE, VMax,   11'd0,    1, '{ST_OK,    11'd2, 11'd1, 64'd0, 11'd3}},
        '{OP_PROBE, VMin,   11'd0,    1, '{ST_OK,    11'd2, 11'd2, 64'd0, 11'd3}},
        '{OP_PUSH,  64'sh5555_5555_5555_5555, 11'h555, 0, '0},
        '{OP_PUSH,  64'shAAAA_AAAA_AAAA_AAAA, 11'h2AA, 0, '0},
        '{OP_PUSH,  64'sd0,  11'd0,   0, '0},
        '{OP_PUSH,  64'sd0,  11'd0,   0, '0},
        '{OP_PROBE, 64'sd0,  11'd0,   0, '0},
        '{OP_POP,   64'sd0,  11'd0,   0, '0},
        '{OP_POP,   64'sd0,  11'd0,   0, '0},
        '{OP_POP,   64'sd0,  11'd0,   0, '0},
        '{OP_POP,   64'sd0,  11'd0,   0, '0},
        '{OP_POP,   64'sd0,  11'd0,   0, '0},
        '{OP_POP,   64'sd0,  11'd0,   0, '0},
        '{OP_POP,   64'sd0,  11'd0,   1, '{ST_OK,    11'd0, 11'd1, 64'd0, 11'd0}}
    };

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(1'b1);
        foreach (table_rows[i])
            send(table_rows[i].op, table_rows[i].value, table_rows[i].rank,
                 table_rows[i].typed, table_rows[i].res);

        // ties behave differently in the non-strict mode
        write_mode(1'b0);
        random_mix(350, 45, 25);
        write_mode(1'b1);
        random_mix(150, 45, 25);
        // fill past full, mixing modes so undo crosses a mode change
        write_mode(1'b0);
        while (elem_cnt < Depth) random_mix(1, 90, 0);
        repeat (12) send(OP_PUSH, any_value(), '0);
        write_mode(1'b1);
        random_mix(300, 10, 70);
        send(OP_POP, VMax, '0);
        i_in_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d requests and %0d results in both modes", n_req, n_res);
        $display("status hits: full %0d, empty pop %0d, bad rank %0d",
                 n_full, n_empty, n_rank);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/lpt_pkg.sv
sv/lpt_cell.sv
sv/lds_patience_tracker_with_undo_core.sv
bench/tb_lds_patience_tracker_with_undo_core.sv
